// ===== rtl/json_string_unescape_utf8_assert.svh =====
// Assertion macros shared by the checker of the JSON string unescaper.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, constants and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Width of the saturating decoded-byte counter and of the reported length.
   localparam int LenBits    = 16;
   localparam int OutLenBits = 16;

   // Command queue between the classifier and the emitter.
   localparam int QueueDepth    = 4;
   localparam int QueuePtrBits  = $clog2(QueueDepth);
   localparam int QueueFillBits = $clog2(QueueDepth + 1);

   // Characters of interest.
   localparam logic [7:0] ChQuote  = 8'h22;
   localparam logic [7:0] ChBslash = 8'h5C;
   localparam logic [7:0] ChSlash  = 8'h2F;
   localparam logic [7:0] ChLowB   = 8'h62;
   localparam logic [7:0] ChLowF   = 8'h66;
   localparam logic [7:0] ChLowN   = 8'h6E;
   localparam logic [7:0] ChLowR   = 8'h72;
   localparam logic [7:0] ChLowT   = 8'h74;
   localparam logic [7:0] ChLowU   = 8'h75;
   localparam logic [7:0] ChNul    = 8'h00;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChBs     = 8'h08;
   localparam logic [7:0] ChFf     = 8'h0C;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChTab    = 8'h09;

   // Top six bits of high and low surrogate code units.
   localparam logic [5:0] HighSurrTag = 6'b110110;
   localparam logic [5:0] LowSurrTag  = 6'b110111;
   localparam logic [20:0] SuppBase   = 21'h10000;

   typedef enum logic [2:0] {
      PH_AWAIT,
      PH_BODY,
      PH_ESC,
      PH_HEX_FIRST,
      PH_WANT_BSLASH,
      PH_WANT_U,
      PH_HEX_SECOND
   } phase_type;

   typedef enum logic [2:0] {
      ST_CONT,
      ST_DONE,
      ST_NO_CLOSE,
      ST_BAD_ESC,
      ST_BAD_HEX,
      ST_BAD_SURR,
      ST_CTRL,
      ST_NO_OPEN
   } status_type;

   // One queued command: up to four bytes to emit, or a single byte-less
   // result carrying a status.
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      nbytes;
      status_type      status;
   } cmd_type;

   // Returns {is_hex, digit value}.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   // UTF-8 encoding of a code point of up to 21 bits.
   function automatic cmd_type utf8_encode(input logic [20:0] u);
      cmd_type c;
      c = '0;
      c.status = ST_CONT;
      if (u <= 21'h7F) begin
         c.data[0] = u[7:0];
         c.nbytes  = 3'd1;
      end else if (u <= 21'h7FF) begin
         c.data[0] = {3'b110, u[10:6]};
         c.data[1] = {2'b10, u[5:0]};
         c.nbytes  = 3'd2;
      end else if (u <= 21'hFFFF) begin
         c.data[0] = {4'b1110, u[15:12]};
         c.data[1] = {2'b10, u[11:6]};
         c.data[2] = {2'b10, u[5:0]};
         c.nbytes  = 3'd3;
      end else begin
         c.data[0] = {5'b11110, u[20:18]};
         c.data[1] = {2'b10, u[17:12]};
         c.data[2] = {2'b10, u[11:6]};
         c.data[3] = {2'b10, u[5:0]};
         c.nbytes  = 3'd4;
      end
      return c;
   endfunction

endpackage

// ===== rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Classifies each text byte, tracks the escape state and queues a command.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_text_byte,
   input  logic       queue_full,
   output logic       req_ready,
   output logic       push,
   output cmd_type    cmd
);

   phase_type   phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  digits_ff, digits_in;
   logic [9:0]  high_ff, high_in;

   logic [4:0]  hex;
   logic [15:0] acc_new;
   status_type  st;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign hex       = hex_value(req_text_byte);
   assign acc_new   = {acc_ff[11:0], hex[3:0]};

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      high_in   = high_ff;
      st        = ST_CONT;
      cmd       = '0;
      cmd.status = ST_CONT;

      unique case (phase_ff)
         PH_BODY: begin
            priority if (req_text_byte == ChQuote) begin
               st = ST_DONE;
            end else if (req_text_byte == ChBslash) begin
               phase_in = PH_ESC;
            end else if (req_text_byte == ChNul) begin
               st = ST_NO_CLOSE;
            end else if (req_text_byte < ChSpace) begin
               st = ST_CTRL;
            end else begin
               cmd.data[0] = req_text_byte;
               cmd.nbytes  = 3'd1;
            end
         end
         PH_ESC: begin
            phase_in = PH_BODY;
            cmd.nbytes = 3'd1;
            unique case (req_text_byte)
               ChQuote, ChBslash, ChSlash: cmd.data[0] = req_text_byte;
               ChLowB: cmd.data[0] = ChBs;
               ChLowF: cmd.data[0] = ChFf;
               ChLowN: cmd.data[0] = ChLf;
               ChLowR: cmd.data[0] = ChCr;
               ChLowT: cmd.data[0] = ChTab;
               ChLowU: begin
                  cmd.nbytes = 3'd0;
                  phase_in   = PH_HEX_FIRST;
                  acc_in     = 16'd0;
                  digits_in  = 2'd0;
               end
               default: begin
                  cmd.nbytes = 3'd0;
                  st         = ST_BAD_ESC;
               end
            endcase
         end
         PH_HEX_FIRST, PH_HEX_SECOND: begin
            if (!hex[4]) begin
               st = ST_BAD_HEX;
            end else begin
               acc_in = acc_new;
               if (digits_ff != 2'd3) begin
                  digits_in = digits_ff + 2'd1;
               end else begin
                  digits_in = 2'd0;
                  if (phase_ff == PH_HEX_FIRST) begin
                     if (acc_new[15:10] == HighSurrTag) begin
                        high_in  = acc_new[9:0];
                        phase_in = PH_WANT_BSLASH;
                     end else begin
                        cmd      = utf8_encode(21'(acc_new));
                        phase_in = PH_BODY;
                     end
                  end else if (acc_new[15:10] == LowSurrTag) begin
                     cmd      = utf8_encode(SuppBase + 21'({high_ff, acc_new[9:0]}));
                     phase_in = PH_BODY;
                  end else begin
                     st = ST_BAD_SURR;
                  end
               end
            end
         end
         PH_WANT_BSLASH: begin
            if (req_text_byte == ChBslash) phase_in = PH_WANT_U;
            else st = ST_BAD_SURR;
         end
         PH_WANT_U: begin
            if (req_text_byte == ChLowU) begin
               phase_in  = PH_HEX_SECOND;
               acc_in    = 16'd0;
               digits_in = 2'd0;
            end else begin
               st = ST_BAD_SURR;
            end
         end
         default: begin
            if (req_text_byte == ChQuote) phase_in = PH_BODY;
            else st = ST_NO_OPEN;
         end
      endcase

      // A final status ends the string and re-arms for the next one.
      if (st != ST_CONT) begin
         cmd.nbytes = 3'd0;
         cmd.status = st;
         phase_in   = PH_AWAIT;
         acc_in     = 16'd0;
         digits_in  = 2'd0;
         high_in    = 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_AWAIT;
         acc_ff    <= 16'd0;
         digits_ff <= 2'd0;
         high_ff   <= 10'd0;
      end else if (push) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         high_ff   <= high_in;
      end
   end

endmodule

// ===== rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Small register FIFO of commands between classifier and emitter.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   cmd_type                   slot_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueFillBits-1:0]  fill_ff;
   logic                      do_push, do_pop;

   assign empty   = (fill_ff == QueueFillBits'(0));
   assign full    = (fill_ff == QueueFillBits'(QueueDepth));
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   function automatic logic [QueuePtrBits-1:0] bump(input logic [QueuePtrBits-1:0] p);
      return (p == QueuePtrBits'(QueueDepth - 1)) ? QueuePtrBits'(0) : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= bump(wr_ptr_ff);
         if (do_pop)  rd_ptr_ff <= bump(rd_ptr_ff);
         if (do_push && !do_pop) fill_ff <= fill_ff + 1'b1;
         else if (do_pop && !do_push) fill_ff <= fill_ff - 1'b1;
      end
   end

endmodule

// ===== rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Expands queued commands into results, keeps the decoded-byte count.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               head,
   input  logic                  queue_empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_valid,
   output logic [2:0]            rsp_status,
   output logic [OutLenBits-1:0] rsp_string_length,
   output logic                  rsp_last
);

   logic                  valid_ff;
   logic [1:0]            idx_ff;
   logic [LenBits-1:0]    count_ff, count_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  bvalid_ff, bvalid_in;
   status_type            status_ff, status_in;
   logic [OutLenBits-1:0] len_ff, len_in;
   logic                  last_ff, last_in;

   logic                  load, fire, is_last;
   logic [2:0]            nres;
   logic [LenBits-1:0]    count_inc;

   assign load      = !valid_ff || rsp_ready;
   assign fire      = load && !queue_empty;
   assign nres      = (head.nbytes == 3'd0) ? 3'd1 : head.nbytes;
   assign is_last   = ({1'b0, idx_ff} + 3'd1) == nres;
   assign pop       = fire && is_last;
   assign count_inc = (count_ff == {LenBits{1'b1}}) ? count_ff : count_ff + 1'b1;

   always_comb begin
      count_in  = count_ff;
      byte_in   = 8'd0;
      bvalid_in = 1'b0;
      status_in = head.status;
      len_in    = OutLenBits'(count_ff);
      last_in   = is_last;
      if (head.nbytes != 3'd0) begin
         byte_in   = head.data[idx_ff];
         bvalid_in = 1'b1;
         status_in = ST_CONT;
         count_in  = count_inc;
         len_in    = OutLenBits'(count_inc);
      end else if (head.status != ST_CONT) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
         count_ff <= '0;
      end else if (load) begin
         valid_ff <= !queue_empty;
         if (fire) begin
            idx_ff   <= is_last ? 2'd0 : idx_ff + 2'd1;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff   <= byte_in;
         bvalid_ff <= bvalid_in;
         status_ff <= status_in;
         len_ff    <= len_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_out_valid     = bvalid_ff;
   assign rsp_status        = status_ff;
   assign rsp_string_length = len_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== rtl/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming decoder of one quoted JSON string into UTF-8 bytes.
// ----------------------------------------------------------------------------
// The req channel takes the text one byte per request (zero ends the text).
// The rsp channel returns, per request, one to four results: a decoded byte
// with out_valid set, or a byte-less result; last marks the final result of
// a request, and a nonzero status closes the string with its outcome and
// the decoded length (saturating). After a final status the block waits for
// the opening quote of the next string.
// An accepted request is written into the command queue, and its first
// result is registered in the emitter output stage. Throughput is one
// request per cycle as long as each request yields one result and the
// receiver is ready; the last hex digit of a \u escape yields up to four
// results, which the emitter sends one per cycle while rsp_ready is high.
// A four-entry command queue between classifier and emitter absorbs these
// bursts and receiver stalls; req_ready drops only when the queue is full.
// Synchronous reset empties the queue, drops rsp_valid and re-arms the
// classifier for an opening quote. While rsp_ready is low the current
// result is held unchanged.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_text_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_valid,
   output logic [2:0]            rsp_status,
   output logic [OutLenBits-1:0] rsp_string_length,
   output logic                  rsp_last
);

   // Classifier to queue.
   logic    push;
   cmd_type push_cmd;

   // Queue to emitter.
   cmd_type head;
   logic    queue_empty;
   logic    queue_full;
   logic    pop;

   // The classifier decides per byte what it produces and updates the
   // escape and surrogate state as soon as the byte is accepted.
   jsu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_text_byte (req_text_byte),
      .queue_full    (queue_full),
      .req_ready     (req_ready),
      .push          (push),
      .cmd           (push_cmd)
   );

   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // The emitter walks the bytes of the head command, one result per cycle
   // unless stalled, and counts decoded bytes till a final status clears it.
   jsu_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .queue_empty       (queue_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_status        (rsp_status),
      .rsp_string_length (rsp_string_length),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== rtl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// jsu_checker
// Port-level checks of the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_assert.svh"

module jsu_checker import jsu_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [7:0]            req_text_byte,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [7:0]            rsp_out_byte,
   input logic                  rsp_out_valid,
   input logic [2:0]            rsp_status,
   input logic [OutLenBits-1:0] rsp_string_length,
   input logic                  rsp_last
);

   // A stalled result must hold still.
   `JSU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_status) && $stable(rsp_string_length) && $stable(rsp_last), "rsp changed while stalled")

   // A result without a decoded byte carries a zero byte.
   `JSU_ASSERT_NOW(a_empty_byte, rsp_valid && !rsp_out_valid, rsp_out_byte == 8'd0, "byte-less result has nonzero byte")

   // A final status is always the last result of its request and has no byte.
   `JSU_ASSERT_NOW(a_final_last, rsp_valid && rsp_status != ST_CONT, rsp_last && !rsp_out_valid, "final status not last or carries a byte")

   // The first cycle after reset shows no result.
   `JSU_ASSERT_NOW(a_reset_quiet, $past(reset), !rsp_valid, "result right after reset")

endmodule

bind json_string_unescape_utf8 jsu_checker u_checker (.*);

// ===== tb/utf8_decode_checker.sv =====
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches both channels of the JSON string unescaper and checks its results.
// ----------------------------------------------------------------------------
// Every accepted request is run through a local decoder that keeps its own
// phase, hex digits, pending high surrogate and saturating byte count. The
// results it predicts are queued, and each accepted result is compared field
// by field with the oldest entry.
// ----------------------------------------------------------------------------
module utf8_decode_checker import jsu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [7:0]            req_text_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [7:0]            rsp_out_byte,
   input  logic                  rsp_out_valid,
   input  logic [2:0]            rsp_status,
   input  logic [OutLenBits-1:0] rsp_string_length,
   input  logic                  rsp_last,
   output int                    mismatches,
   output int                    results_outstanding,
   output int                    results_checked,
   output int                    strings_done,
   output int                    strings_failed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]            data;
      logic                  data_valid;
      status_type            status;
      logic [OutLenBits-1:0] length;
      logic                  last;
   } decoded_result_type;

   decoded_result_type expected_decodes[$];
   decoded_result_type burst[$];

   phase_type         phase;
   logic [15:0]       hex_acc;
   logic [1:0]        hex_digits;
   logic [9:0]        high_surr;
   logic [LenBits-1:0] decoded_count;

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
               results_checked, field, got, want);
      mismatches++;
   endtask

   // The count saturates at its all-ones value and only counts real bytes.
   function automatic void add_result(input logic [7:0] data, input logic data_valid,
                                      input status_type st);
      decoded_result_type r;
      if (data_valid && decoded_count != '1) decoded_count++;
      r.data       = data_valid ? data : 8'h00;
      r.data_valid = data_valid;
      r.status     = st;
      r.length     = OutLenBits'(decoded_count);
      r.last       = 1'b0;
      burst.push_back(r);
   endfunction

   function automatic void encode_code_point(input logic [20:0] cp);
      if (cp <= 21'h7F) begin
         add_result(cp[7:0], 1'b1, ST_CONT);
      end else if (cp <= 21'h7FF) begin
         add_result({3'b110, cp[10:6]}, 1'b1, ST_CONT);
         add_result({2'b10, cp[5:0]}, 1'b1, ST_CONT);
      end else if (cp <= 21'hFFFF) begin
         add_result({4'b1110, cp[15:12]}, 1'b1, ST_CONT);
         add_result({2'b10, cp[11:6]}, 1'b1, ST_CONT);
         add_result({2'b10, cp[5:0]}, 1'b1, ST_CONT);
      end else begin
         add_result({5'b11110, cp[20:18]}, 1'b1, ST_CONT);
         add_result({2'b10, cp[17:12]}, 1'b1, ST_CONT);
         add_result({2'b10, cp[11:6]}, 1'b1, ST_CONT);
         add_result({2'b10, cp[5:0]}, 1'b1, ST_CONT);
      end
   endfunction

   function automatic void clear_decoder();
      phase         = PH_AWAIT;
      hex_acc       = '0;
      hex_digits    = '0;
      high_surr     = '0;
      decoded_count = '0;
   endfunction

   function automatic void predict_text_byte(input logic [7:0] b);
      status_type         st;
      logic               is_digit;
      logic [3:0]         digit;
      decoded_result_type tail;
      st = ST_CONT;
      burst.delete();
      case (phase)
         PH_BODY: begin
            if (b == ChQuote) st = ST_DONE;
            else if (b == ChBslash) phase = PH_ESC;
            else if (b == ChNul) st = ST_NO_CLOSE;
            else if (b < ChSpace) st = ST_CTRL;
            else add_result(b, 1'b1, ST_CONT);
         end
         PH_ESC: begin
            phase = PH_BODY;
            case (b)
               ChQuote, ChBslash, ChSlash: add_result(b, 1'b1, ST_CONT);
               ChLowB: add_result(ChBs, 1'b1, ST_CONT);
               ChLowF: add_result(ChFf, 1'b1, ST_CONT);
               ChLowN: add_result(ChLf, 1'b1, ST_CONT);
               ChLowR: add_result(ChCr, 1'b1, ST_CONT);
               ChLowT: add_result(ChTab, 1'b1, ST_CONT);
               ChLowU: begin
                  phase      = PH_HEX_FIRST;
                  hex_acc    = '0;
                  hex_digits = '0;
               end
               default: st = ST_BAD_ESC;
            endcase
         end
         PH_HEX_FIRST, PH_HEX_SECOND: begin
            is_digit = 1'b1;
            digit    = 4'd0;
            if (b >= 8'h30 && b <= 8'h39) digit = 4'(b - 8'h30);
            else if (b >= 8'h61 && b <= 8'h66) digit = 4'(b - 8'h61 + 8'd10);
            else if (b >= 8'h41 && b <= 8'h46) digit = 4'(b - 8'h41 + 8'd10);
            else is_digit = 1'b0;
            if (!is_digit) begin
               st = ST_BAD_HEX;
            end else begin
               hex_acc = {hex_acc[11:0], digit};
               if (hex_digits != 2'd3) begin
                  hex_digits++;
               end else begin
                  hex_digits = '0;
                  if (phase == PH_HEX_FIRST) begin
                     if (hex_acc inside {[16'hD800:16'hDBFF]}) begin
                        high_surr = hex_acc[9:0];
                        phase     = PH_WANT_BSLASH;
                     end else begin
                        encode_code_point(21'(hex_acc));
                        phase = PH_BODY;
                     end
                  end else if (hex_acc inside {[16'hDC00:16'hDFFF]}) begin
                     // Pair: 0x10000 plus ten bits from each half.
                     encode_code_point(21'h10000 + 21'({high_surr, hex_acc[9:0]}));
                     phase = PH_BODY;
                  end else begin
                     st = ST_BAD_SURR;
                  end
               end
            end
         end
         PH_WANT_BSLASH: begin
            if (b == ChBslash) phase = PH_WANT_U;
            else st = ST_BAD_SURR;
         end
         PH_WANT_U: begin
            if (b == ChLowU) begin
               phase      = PH_HEX_SECOND;
               hex_acc    = '0;
               hex_digits = '0;
            end else begin
               st = ST_BAD_SURR;
            end
         end
         default: begin
            if (b == ChQuote) begin
               phase         = PH_BODY;
               decoded_count = '0;
            end else begin
               st = ST_NO_OPEN;
            end
         end
      endcase

      // A final status reports the count reached, then the decoder re-arms.
      if (st != ST_CONT) begin
         add_result(8'h00, 1'b0, st);
         clear_decoder();
      end else if (burst.size() == 0) begin
         add_result(8'h00, 1'b0, ST_CONT);
      end
      tail      = burst.pop_back();
      tail.last = 1'b1;
      burst.push_back(tail);
      foreach (burst[i]) expected_decodes.push_back(burst[i]);
   endfunction

   always @(posedge clock) begin : watch
      decoded_result_type want;
      if (reset) begin
         clear_decoder();
         expected_decodes.delete();
         mismatches      = 0;
         results_checked = 0;
         strings_done    = 0;
         strings_failed  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_decodes.size() == 0) begin
               report_mismatch("unexpected result", {rsp_out_valid, rsp_out_byte}, 0);
            end else begin
               want = expected_decodes.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch("out_byte", rsp_out_byte, want.data);
               if (rsp_out_valid !== want.data_valid)
                  report_mismatch("out_valid", rsp_out_valid, want.data_valid);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_string_length !== want.length)
                  report_mismatch("string_length", rsp_string_length, want.length);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
            if (rsp_status == ST_DONE) strings_done++;
            else if (rsp_status != ST_CONT) strings_failed++;
            results_checked++;
         end
         if (req_valid && req_ready) predict_text_byte(req_text_byte);
      end
      results_outstanding = expected_decodes.size();
   end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the JSON string unescaper.
// ----------------------------------------------------------------------------
// Feeds quoted JSON strings one byte per request: a directed opening run,
// then random strings built from plain bytes, simple escapes, \u escapes
// and surrogate pairs, ended by a closing quote or by one of the error
// cases. Both channels idle at random; a checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb import jsu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycle limit of the watchdog and the number of random text bytes.
   localparam int CycleLimit  = 20000;
   localparam int RandomBytes = 220;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_text_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_out_valid;
   logic [2:0]            rsp_status;
   logic [OutLenBits-1:0] rsp_string_length;
   logic                  rsp_last;

   int   mismatches;
   int   results_outstanding;
   int   results_checked;
   int   strings_done;
   int   strings_failed;
   int   cycle_count = 0;
   int   bytes_sent  = 0;
   // While set, neither side idles.
   logic no_idle     = 1'b0;

   // The directed run: no opening quote (zero, then a high byte), a body with
   // high bytes, a space, an escape and a 4-byte surrogate pair, an empty
   // string, a raw control byte, and a lone low surrogate followed by the
   // end of text inside the body.
   logic [7:0] directed_bytes[] = '{
      8'h00, 8'hFF,
      ChQuote, 8'h80, 8'hFF, ChSpace, ChBslash, ChLowN,
      ChBslash, ChLowU, "D", "8", "3", "d",
      ChBslash, ChLowU, "d", "E", "0", "0", ChQuote,
      ChQuote, ChQuote,
      ChQuote, 8'h01,
      ChQuote, ChBslash, ChLowU, "D", "C", "0", "0", ChNul
   };

   json_string_unescape_utf8 u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_valid     (rsp_out_valid),
      .rsp_status        (rsp_status),
      .rsp_string_length (rsp_string_length),
      .rsp_last          (rsp_last)
   );

   utf8_decode_checker u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_text_byte       (req_text_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_out_valid       (rsp_out_valid),
      .rsp_status          (rsp_status),
      .rsp_string_length   (rsp_string_length),
      .rsp_last            (rsp_last),
      .mismatches          (mismatches),
      .results_outstanding (results_outstanding),
      .results_checked     (results_checked),
      .strings_done        (strings_done),
      .strings_failed      (strings_failed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver stalls with a probability of about six percent.
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 6);
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, results_outstanding);
         $display("Verification failed");
         $finish;
      end
   end

   // Presents one text byte and holds it until the block takes it. A random
   // pause, with valid low, may come first; valid is lowered only in a step
   // where it is not raised again.
   task automatic send_text_byte(input logic [7:0] b);
      if (!no_idle && $urandom_range(99) < 3) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Hex digits come in either case at random.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   // A \u escape carrying one 16-bit code unit.
   task automatic send_code_unit(input logic [15:0] u);
      send_text_byte(ChBslash);
      send_text_byte(ChLowU);
      send_text_byte(hex_char(u[15:12]));
      send_text_byte(hex_char(u[11:8]));
      send_text_byte(hex_char(u[7:4]));
      send_text_byte(hex_char(u[3:0]));
   endtask

   // One random string. Most are well formed with random content; a few are
   // bare noise bytes at the start, and about a third end in an error.
   task automatic send_random_string();
      int          kind;
      int          good_digits;
      logic [7:0]  b;
      logic [15:0] u;
      if ($urandom_range(99) < 8) begin
         send_text_byte(8'($urandom_range(255)));
         return;
      end
      send_text_byte(ChQuote);
      repeat ($urandom_range(0, 8)) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            do b = 8'($urandom_range(8'h20, 8'hFF));
            while (b == ChQuote || b == ChBslash);
            send_text_byte(b);
         end else if (kind < 65) begin
            send_text_byte(ChBslash);
            case ($urandom_range(7))
               0: send_text_byte(ChQuote);
               1: send_text_byte(ChBslash);
               2: send_text_byte(ChSlash);
               3: send_text_byte(ChLowB);
               4: send_text_byte(ChLowF);
               5: send_text_byte(ChLowN);
               6: send_text_byte(ChLowR);
               default: send_text_byte(ChLowT);
            endcase
         end else begin
            // Code units of every encoded length, with their extremes now
            // and then, lone low surrogates, and surrogate pairs.
            case ($urandom_range(4))
               0: begin
                  u = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom_range(16'h7F));
                  send_code_unit(u);
               end
               1: send_code_unit(16'($urandom_range(16'h80, 16'h7FF)));
               2: begin
                  do u = ($urandom_range(3) == 0) ? 16'hFFFF
                                                  : 16'($urandom_range(16'h800, 16'hFFFF));
                  while (u inside {[16'hD800:16'hDFFF]});
                  send_code_unit(u);
               end
               3: send_code_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
               default: begin
                  send_code_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
                  send_code_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
               end
            endcase
         end
      end

      kind = $urandom_range(99);
      if (kind < 66) begin
         send_text_byte(ChQuote);
      end else if (kind < 71) begin
         // End of text inside the body.
         send_text_byte(ChNul);
      end else if (kind < 77) begin
         send_text_byte(8'($urandom_range(1, 8'h1F)));
      end else if (kind < 84) begin
         // Unknown escape letter, zero included.
         send_text_byte(ChBslash);
         do b = 8'($urandom_range(255));
         while (b inside {ChQuote, ChBslash, ChSlash, ChLowB, ChLowF,
                          ChLowN, ChLowR, ChLowT, ChLowU});
         send_text_byte(b);
      end else if (kind < 91) begin
         // A non-hex byte after zero to three good digits.
         send_text_byte(ChBslash);
         send_text_byte(ChLowU);
         good_digits = $urandom_range(3);
         repeat (good_digits) send_text_byte(hex_char(4'($urandom_range(15))));
         do b = ($urandom_range(3) == 0) ? ChNul : 8'($urandom_range(255));
         while (b inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
         send_text_byte(b);
      end else begin
         // A high surrogate not followed by a proper low one.
         send_code_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
         case ($urandom_range(2))
            0: begin
               do b = 8'($urandom_range(255));
               while (b == ChBslash);
               send_text_byte(b);
            end
            1: begin
               send_text_byte(ChBslash);
               do b = 8'($urandom_range(255));
               while (b == ChLowU);
               send_text_byte(b);
            end
            default: begin
               do u = 16'($urandom_range(16'hFFFF));
               while (u inside {[16'hDC00:16'hDFFF]});
               send_code_unit(u);
            end
         endcase
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_text_byte <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i]) send_text_byte(directed_bytes[i]);

      // Random strings; the middle stretch runs with no idling on either side.
      while (bytes_sent < directed_bytes.size() + RandomBytes) begin
         no_idle = (bytes_sent >= directed_bytes.size() + RandomBytes / 3) &&
                   (bytes_sent <  directed_bytes.size() + 2 * RandomBytes / 3);
         send_random_string();
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;

      // Drain the expected results, then give a stray result time to show up.
      @(negedge clock);
      while (results_outstanding != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);

      $display("Sent %0d text bytes and checked %0d results.", bytes_sent, results_checked);
      $display("Strings closed: %0d decoded, %0d ended by an error status.",
               strings_done, strings_failed);
      if (mismatches == 0 && results_outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
